// ===== design/cpu_register_file_stack_unit_defines.svh =====
// Assertion macros shared by the register file and stack unit.
`ifndef CPU_REGISTER_FILE_STACK_UNIT_DEFINES_SVH
`define CPU_REGISTER_FILE_STACK_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define CRFS_ASSERT_SAME(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("crfs assertion failed");

// The condition must hold in the cycle after the trigger.
`define CRFS_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("crfs assertion failed");

`endif

// ===== design/crfs_pkg.sv =====
package crfs_pkg;

   localparam logic [2:0] REQ_READ     = 3'd0;
   localparam logic [2:0] REQ_WRITE    = 3'd1;
   localparam logic [2:0] REQ_PUSH     = 3'd2;
   localparam logic [2:0] REQ_POP      = 3'd3;
   localparam logic [2:0] REQ_FLAGS    = 3'd4;
   localparam logic [2:0] REQ_JUMP     = 3'd5;
   localparam logic [2:0] REQ_MEM_DATA = 3'd6;

   localparam logic [3:0] SEL_AF  = 4'd8;
   localparam logic [3:0] SEL_BC  = 4'd9;
   localparam logic [3:0] SEL_DE  = 4'd10;
   localparam logic [3:0] SEL_HL  = 4'd11;
   localparam logic [3:0] SEL_SP  = 4'd12;
   localparam logic [3:0] SEL_PC  = 4'd13;
   localparam logic [3:0] SEL_MEM = 4'd14;
   localparam logic [3:0] SEL_BAD = 4'd15;

   localparam logic [2:0] REG_A = 3'd0;
   localparam logic [2:0] REG_B = 3'd1;
   localparam logic [2:0] REG_C = 3'd2;
   localparam logic [2:0] REG_D = 3'd3;
   localparam logic [2:0] REG_E = 3'd4;
   localparam logic [2:0] REG_F = 3'd5;
   localparam logic [2:0] REG_H = 3'd6;
   localparam logic [2:0] REG_L = 3'd7;

   localparam logic [2:0] COND_ALWAYS = 3'd0;
   localparam logic [2:0] COND_C      = 3'd1;
   localparam logic [2:0] COND_NC     = 3'd2;
   localparam logic [2:0] COND_Z      = 3'd3;
   localparam logic [2:0] COND_NZ     = 3'd4;

   localparam logic [1:0] FLAG_CLEAR = 2'd0;
   localparam logic [1:0] FLAG_SET   = 2'd1;

   localparam int FLAG_Z = 7;
   localparam int FLAG_N = 6;
   localparam int FLAG_H = 5;
   localparam int FLAG_C = 4;

   localparam logic [7:0] F_PAIR_MASK = 8'hF0;

   typedef enum logic [2:0] {
      KIND_DATA  = 3'd0,
      KIND_BUSRD = 3'd1,
      KIND_BUSWR = 3'd2,
      KIND_DONE  = 3'd3,
      KIND_ERR   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  reg_sel;
      logic [15:0] value;
      logic [1:0]  z_ctl;
      logic [1:0]  n_ctl;
      logic [1:0]  h_ctl;
      logic [1:0]  c_ctl;
      logic [2:0]  cond_sel;
      logic        push_return;
      logic [7:0]  mem_byte;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] bus_addr;
      logic [15:0] data;
      logic        taken;
   } result_type;

   typedef struct packed {
      logic [1:0]           count;
      result_type [2:0]     results;
   } bundle_type;

endpackage

// ===== design/cpu_register_file_stack_unit.sv =====
// A taken request is registered in the input stage, then its results load into the
// three-entry result buffer once it is free; each request has one to three result beats,
// drained one beat per cycle unless stalled; the next request can wait in the input stage.
// Reset: synchronous, active high; clears all registers, SP, PC and pending reads.
`include "cpu_register_file_stack_unit_defines.svh"

module cpu_register_file_stack_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_reg_sel,
   input  logic [15:0] req_value,
   input  logic [1:0]  req_z_ctl,
   input  logic [1:0]  req_n_ctl,
   input  logic [1:0]  req_h_ctl,
   input  logic [1:0]  req_c_ctl,
   input  logic [2:0]  req_cond_sel,
   input  logic        req_push_return,
   input  logic [7:0]  req_mem_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_bus_addr,
   output logic [15:0] rsp_data,
   output logic        rsp_taken,
   output logic        rsp_last
);

   crfs_pkg::item_type   item_ff;
   crfs_pkg::item_type   item_in;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 accept;
   logic                 commit;
   logic                 free;
   crfs_pkg::bundle_type bundle;
   crfs_pkg::result_type head;

   assign commit    = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   assign item_in.req_type    = req_type;
   assign item_in.reg_sel     = req_reg_sel;
   assign item_in.value       = req_value;
   assign item_in.z_ctl       = req_z_ctl;
   assign item_in.n_ctl       = req_n_ctl;
   assign item_in.h_ctl       = req_h_ctl;
   assign item_in.c_ctl       = req_c_ctl;
   assign item_in.cond_sel    = req_cond_sel;
   assign item_in.push_return = req_push_return;
   assign item_in.mem_byte    = req_mem_byte;

   assign in_valid_in = accept || (in_valid_ff && !free);

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   crfs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .item   (item_ff),
      .bundle (bundle)
   );

   crfs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (commit),
      .bundle    (bundle),
      .rsp_stall (rsp_stall),
      .free      (free),
      .valid     (rsp_valid),
      .last      (rsp_last),
      .head      (head)
   );

   assign rsp_kind     = head.kind;
   assign rsp_bus_addr = head.bus_addr;
   assign rsp_data     = head.data;
   assign rsp_taken    = head.taken;

   `CRFS_ASSERT_SAME(a_commit_has_results, clock, reset, commit, bundle.count != 2'd0)
   `CRFS_ASSERT_NEXT(a_drained_goes_idle, clock, reset, rsp_valid && !rsp_stall && rsp_last && !commit, !rsp_valid)
   `CRFS_ASSERT_SAME(a_buswr_is_byte, clock, reset, rsp_valid && rsp_kind == crfs_pkg::KIND_BUSWR, rsp_data[15:8] == 8'h00)

endmodule

// ===== design/crfs_core.sv =====
module crfs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 commit,
   input  crfs_pkg::item_type   item,
   output crfs_pkg::bundle_type bundle
);

   logic [7:0]  byte_regs_ff [8];
   logic [7:0]  byte_regs_in [8];
   logic [15:0] sp_ff;
   logic [15:0] sp_in;
   logic [15:0] pc_ff;
   logic [15:0] pc_in;
   logic [1:0]  pend_ff;
   logic [1:0]  pend_in;
   logic        pend_pop_ff;
   logic        pend_pop_in;
   logic [7:0]  popped_low_ff;
   logic [7:0]  popped_low_in;

   logic [15:0] hl;
   logic [15:0] sp_m1;
   logic [15:0] sp_m2;
   logic [15:0] sp_p1;
   logic [15:0] sp_p2;
   logic [7:0]  flags;
   logic        cond_ok;
   logic [15:0] read_data;

   function automatic logic apply_flag(logic [1:0] ctl, logic old);
      logic res;
      case (ctl)
         crfs_pkg::FLAG_CLEAR: res = 1'b0;
         crfs_pkg::FLAG_SET:   res = 1'b1;
         default:              res = old;
      endcase
      return res;
   endfunction

   assign hl    = {byte_regs_ff[crfs_pkg::REG_H], byte_regs_ff[crfs_pkg::REG_L]};
   assign sp_m1 = sp_ff - 16'd1;
   assign sp_m2 = sp_ff - 16'd2;
   assign sp_p1 = sp_ff + 16'd1;
   assign sp_p2 = sp_ff + 16'd2;
   assign flags = byte_regs_ff[crfs_pkg::REG_F];

   always_comb begin
      case (item.cond_sel)
         crfs_pkg::COND_ALWAYS: cond_ok = 1'b1;
         crfs_pkg::COND_C:      cond_ok = flags[crfs_pkg::FLAG_C];
         crfs_pkg::COND_NC:     cond_ok = !flags[crfs_pkg::FLAG_C];
         crfs_pkg::COND_Z:      cond_ok = flags[crfs_pkg::FLAG_Z];
         crfs_pkg::COND_NZ:     cond_ok = !flags[crfs_pkg::FLAG_Z];
         default:               cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      case (item.reg_sel)
         crfs_pkg::SEL_AF: read_data = {byte_regs_ff[crfs_pkg::REG_A],
                                        flags & crfs_pkg::F_PAIR_MASK};
         crfs_pkg::SEL_BC: read_data = {byte_regs_ff[crfs_pkg::REG_B],
                                        byte_regs_ff[crfs_pkg::REG_C]};
         crfs_pkg::SEL_DE: read_data = {byte_regs_ff[crfs_pkg::REG_D],
                                        byte_regs_ff[crfs_pkg::REG_E]};
         crfs_pkg::SEL_HL: read_data = hl;
         crfs_pkg::SEL_SP: read_data = sp_ff;
         crfs_pkg::SEL_PC: read_data = pc_ff;
         default:          read_data = {8'h00, byte_regs_ff[item.reg_sel[2:0]]};
      endcase
   end

   always_comb begin
      byte_regs_in  = byte_regs_ff;
      sp_in         = sp_ff;
      pc_in         = pc_ff;
      pend_in       = pend_ff;
      pend_pop_in   = pend_pop_ff;
      popped_low_in = popped_low_ff;
      bundle        = '0;
      bundle.count  = 2'd1;
      bundle.results[0].kind = crfs_pkg::KIND_ERR;
      case (item.req_type)
         crfs_pkg::REQ_READ: begin
            if (item.reg_sel == crfs_pkg::SEL_MEM) begin
               pend_in     = 2'd1;
               pend_pop_in = 1'b0;
               bundle.results[0].kind     = crfs_pkg::KIND_BUSRD;
               bundle.results[0].bus_addr = hl;
            end else if (item.reg_sel != crfs_pkg::SEL_BAD) begin
               bundle.results[0].kind = crfs_pkg::KIND_DATA;
               bundle.results[0].data = read_data;
            end
         end
         crfs_pkg::REQ_WRITE: begin
            bundle.results[0].kind = crfs_pkg::KIND_DONE;
            case (item.reg_sel)
               crfs_pkg::SEL_BAD: begin
                  bundle.results[0].kind = crfs_pkg::KIND_ERR;
               end
               crfs_pkg::SEL_MEM: begin
                  bundle.results[0].kind     = crfs_pkg::KIND_BUSWR;
                  bundle.results[0].bus_addr = hl;
                  bundle.results[0].data     = {8'h00, item.value[7:0]};
               end
               crfs_pkg::SEL_AF: begin
                  byte_regs_in[crfs_pkg::REG_A] = item.value[15:8];
                  byte_regs_in[crfs_pkg::REG_F] = item.value[7:0] & crfs_pkg::F_PAIR_MASK;
               end
               crfs_pkg::SEL_BC: begin
                  byte_regs_in[crfs_pkg::REG_B] = item.value[15:8];
                  byte_regs_in[crfs_pkg::REG_C] = item.value[7:0];
               end
               crfs_pkg::SEL_DE: begin
                  byte_regs_in[crfs_pkg::REG_D] = item.value[15:8];
                  byte_regs_in[crfs_pkg::REG_E] = item.value[7:0];
               end
               crfs_pkg::SEL_HL: begin
                  byte_regs_in[crfs_pkg::REG_H] = item.value[15:8];
                  byte_regs_in[crfs_pkg::REG_L] = item.value[7:0];
               end
               crfs_pkg::SEL_SP: sp_in = item.value;
               crfs_pkg::SEL_PC: pc_in = item.value;
               default: byte_regs_in[item.reg_sel[2:0]] = item.value[7:0];
            endcase
         end
         crfs_pkg::REQ_PUSH: begin
            bundle.count = 2'd2;
            bundle.results[0].kind     = crfs_pkg::KIND_BUSWR;
            bundle.results[0].bus_addr = sp_m1;
            bundle.results[0].data     = {8'h00, item.value[15:8]};
            bundle.results[1].kind     = crfs_pkg::KIND_BUSWR;
            bundle.results[1].bus_addr = sp_m2;
            bundle.results[1].data     = {8'h00, item.value[7:0]};
            sp_in = sp_m2;
         end
         crfs_pkg::REQ_POP: begin
            bundle.count = 2'd2;
            bundle.results[0].kind     = crfs_pkg::KIND_BUSRD;
            bundle.results[0].bus_addr = sp_ff;
            bundle.results[1].kind     = crfs_pkg::KIND_BUSRD;
            bundle.results[1].bus_addr = sp_p1;
            sp_in       = sp_p2;
            pend_in     = 2'd2;
            pend_pop_in = 1'b1;
         end
         crfs_pkg::REQ_FLAGS: begin
            byte_regs_in[crfs_pkg::REG_F][crfs_pkg::FLAG_Z] =
               apply_flag(item.z_ctl, flags[crfs_pkg::FLAG_Z]);
            byte_regs_in[crfs_pkg::REG_F][crfs_pkg::FLAG_N] =
               apply_flag(item.n_ctl, flags[crfs_pkg::FLAG_N]);
            byte_regs_in[crfs_pkg::REG_F][crfs_pkg::FLAG_H] =
               apply_flag(item.h_ctl, flags[crfs_pkg::FLAG_H]);
            byte_regs_in[crfs_pkg::REG_F][crfs_pkg::FLAG_C] =
               apply_flag(item.c_ctl, flags[crfs_pkg::FLAG_C]);
            bundle.results[0].kind = crfs_pkg::KIND_DONE;
         end
         crfs_pkg::REQ_JUMP: begin
            if (item.cond_sel <= crfs_pkg::COND_NZ) begin
               bundle.results[0].kind = crfs_pkg::KIND_DONE;
               if (cond_ok) begin
                  pc_in = item.value;
                  if (item.push_return) begin
                     bundle.count = 2'd3;
                     bundle.results[0].kind     = crfs_pkg::KIND_BUSWR;
                     bundle.results[0].bus_addr = sp_m1;
                     bundle.results[0].data     = {8'h00, pc_ff[15:8]};
                     bundle.results[1].kind     = crfs_pkg::KIND_BUSWR;
                     bundle.results[1].bus_addr = sp_m2;
                     bundle.results[1].data     = {8'h00, pc_ff[7:0]};
                     bundle.results[2].kind     = crfs_pkg::KIND_DONE;
                     bundle.results[2].taken    = 1'b1;
                     sp_in = sp_m2;
                  end else begin
                     bundle.results[0].taken = 1'b1;
                  end
               end
            end
         end
         crfs_pkg::REQ_MEM_DATA: begin
            if (pend_ff == 2'd0) begin
               bundle.results[0].kind = crfs_pkg::KIND_ERR;
            end else if (pend_pop_ff && pend_ff == 2'd2) begin
               popped_low_in = item.mem_byte;
               pend_in       = 2'd1;
               bundle.results[0].kind = crfs_pkg::KIND_DONE;
            end else if (pend_pop_ff) begin
               pend_in     = 2'd0;
               pend_pop_in = 1'b0;
               bundle.results[0].kind = crfs_pkg::KIND_DATA;
               bundle.results[0].data = {item.mem_byte, popped_low_ff};
            end else begin
               pend_in = 2'd0;
               bundle.results[0].kind = crfs_pkg::KIND_DATA;
               bundle.results[0].data = {8'h00, item.mem_byte};
            end
         end
         default: begin
            bundle.results[0].kind = crfs_pkg::KIND_ERR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            byte_regs_ff[i] <= 8'h00;
         end
         sp_ff         <= 16'h0000;
         pc_ff         <= 16'h0000;
         pend_ff       <= 2'd0;
         pend_pop_ff   <= 1'b0;
         popped_low_ff <= 8'h00;
      end else if (commit) begin
         byte_regs_ff  <= byte_regs_in;
         sp_ff         <= sp_in;
         pc_ff         <= pc_in;
         pend_ff       <= pend_in;
         pend_pop_ff   <= pend_pop_in;
         popped_low_ff <= popped_low_in;
      end
   end

endmodule

// ===== design/crfs_outq.sv =====
module crfs_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  crfs_pkg::bundle_type bundle,
   input  logic                 rsp_stall,
   output logic                 free,
   output logic                 valid,
   output logic                 last,
   output crfs_pkg::result_type head
);

   crfs_pkg::result_type [2:0] results_ff;
   crfs_pkg::result_type [2:0] results_in;
   logic [1:0] rem_ff;
   logic [1:0] rem_in;
   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic       pop;

   assign valid = (rem_ff != 2'd0);
   assign last  = (rem_ff == 2'd1);
   assign head  = results_ff[pos_ff];
   assign pop   = valid && !rsp_stall;
   assign free  = !valid || (last && !rsp_stall);

   always_comb begin
      results_in = results_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      if (load) begin
         results_in = bundle.results;
         rem_in     = bundle.count;
         pos_in     = 2'd0;
      end else if (pop) begin
         rem_in = rem_ff - 2'd1;
         if (!last) begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      results_ff <= results_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         pos_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
      end
   end

endmodule
